>>> design/aiwn_pkg.sv
// Shared types, constants and helpers of the affine inverse warp.
// No dependencies; every other file of the block but aiwn_ram refers to it by scoped names.
package aiwn_pkg;

    // Frame store geometry
    localparam int SRC_MAX_WIDTH  = 512;
    localparam int SRC_MAX_HEIGHT = 512;
    localparam int DST_MAX_SIZE   = 1024;

    localparam int FRAME_DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
    localparam int ADDR_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int SRC_XW = (SRC_MAX_WIDTH > 1) ? $clog2(SRC_MAX_WIDTH) : 1;
    localparam int SRC_YW = (SRC_MAX_HEIGHT > 1) ? $clog2(SRC_MAX_HEIGHT) : 1;

    // Field widths
    localparam int CRD_W  = 10;
    localparam int PIX_W  = 24;
    localparam int COEF_W = 32;
    localparam int SZ_W   = 10;
    localparam int FRAC_W = 16;
    localparam int LIM_W  = 14;
    localparam int PROD_W = COEF_W + CRD_W + 1;
    localparam int ACC_W  = COEF_W + CRD_W + 2;
    localparam int CFG_W  = 32;

    // Decoupling queue
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1) + 1;

    // Register reset values
    localparam logic [COEF_W-1:0] RST_COEF_ONE  = 32'h0001_0000;
    localparam logic [COEF_W-1:0] RST_COEF_ZERO = 32'h0000_0000;
    localparam logic [SZ_W-1:0]   RST_SRC_SIZE  = 10'd512;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_MAP   = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_COEF_XX  = 3'd0,
        CFG_COEF_XY  = 3'd1,
        CFG_OFFSET_X = 3'd2,
        CFG_COEF_YX  = 3'd3,
        CFG_COEF_YY  = 3'd4,
        CFG_OFFSET_Y = 3'd5,
        CFG_SRC_W    = 3'd6,
        CFG_SRC_H    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_cmd             command;
        logic [CRD_W-1:0] coord_x;
        logic [CRD_W-1:0] coord_y;
        logic [PIX_W-1:0] pixel_in;
    } t_item;

    typedef struct packed {
        logic [CRD_W-1:0] dest_x;
        logic [CRD_W-1:0] dest_y;
        logic [PIX_W-1:0] pixel_out;
        logic             inside_res;
    } t_res;

    // One classified command between front and back
    typedef struct packed {
        t_cmd              cmd;
        logic [CRD_W-1:0]  dest_x;
        logic [CRD_W-1:0]  dest_y;
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] addr;
        logic              hit;
    } t_job;

    // True when a signed Q28.16 value lies in [0, size-1], size clamped to lim
    function automatic logic in_range(input logic signed [ACC_W-1:0] v,
                                      input logic [SZ_W-1:0] size,
                                      input logic [LIM_W-1:0] lim);
        logic [LIM_W-1:0] s;
        logic [ACC_W-1:0] bound;
        s = (LIM_W'(size) > lim) ? lim : LIM_W'(size);
        bound = ACC_W'({s - LIM_W'(1), FRAC_W'(0)});
        return (s != '0) && !v[ACC_W-1] && ($unsigned(v) <= bound);
    endfunction

endpackage

>>> design/affine_inverse_warp_nearest.sv
// Affine inverse warp, nearest sample.
// Throughput one command per cycle; the input stalls only when the 8-entry queue and the
// three transform stages together hold 8 commands, i.e. when the output side has stalled.
// Synchronous active-low reset clears handshakes and queue and sets configuration registers to their reset values.
// The frame store has no reset or clearing pass: pixels are undefined until written.
// Depends on aiwn_pkg, aiwn_front, aiwn_queue, aiwn_back, aiwn_ram.
module affine_inverse_warp_nearest (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  aiwn_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [aiwn_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  aiwn_pkg::t_item            i_in_item,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output aiwn_pkg::t_res             o_out_item,
    input  logic                       i_out_stall
);

    // Front to queue
    logic                      push;
    aiwn_pkg::t_job            push_job;
    logic [aiwn_pkg::Q_CW-1:0] q_count;

    // Queue to back
    logic           q_valid;
    logic           q_pop;
    aiwn_pkg::t_job q_job;

    // Front: hold configuration, drop commands outside the store or destination,
    // and transform map coordinates in three stages (register, multiply, sum),
    // with the bounds test and address formed on the way into the queue.
    aiwn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_job      (push_job)
    );

    // Queue: absorb output stalls so the transform pipeline never has to freeze.
    aiwn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    // Back: commands leave the queue in order, so a write always lands in the
    // frame store before any later map reads it.
    aiwn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> design/aiwn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aiwn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/aiwn_front.sv
// Front end: configuration registers, command accept and classification,
// and the three-stage coordinate transform. Depends on aiwn_pkg.
module aiwn_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  aiwn_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [aiwn_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    input  aiwn_pkg::t_item          i_in_item,
    output logic                     o_in_stall,
    input  logic [aiwn_pkg::Q_CW-1:0] i_q_count,
    output logic                     o_push,
    output aiwn_pkg::t_job           o_job
);

    typedef struct packed {
        aiwn_pkg::t_cmd                  cmd;
        logic [aiwn_pkg::CRD_W-1:0]      x;
        logic [aiwn_pkg::CRD_W-1:0]      y;
        logic [aiwn_pkg::PIX_W-1:0]      pix;
        logic [aiwn_pkg::ADDR_W-1:0]     waddr;
    } t_meta;

    logic [aiwn_pkg::COEF_W-1:0] r_coef_xx, r_coef_xy, r_offset_x;
    logic [aiwn_pkg::COEF_W-1:0] r_coef_yx, r_coef_yy, r_offset_y;
    logic [aiwn_pkg::SZ_W-1:0]   r_src_w, r_src_h;

    logic  r_v1, r_v2, r_v3;
    t_meta r_m1, r_m2, r_m3;
    t_meta n_m1;
    logic  n_v1;

    logic signed [aiwn_pkg::PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [aiwn_pkg::PROD_W-1:0] n_pxx, n_pxy, n_pyx, n_pyy;
    logic signed [aiwn_pkg::PROD_W-1:0] ext_xx, ext_xy, ext_yx, ext_yy, ext_x, ext_y;
    logic signed [aiwn_pkg::ACC_W-1:0]  r_sx, r_sy, n_sx, n_sy;

    logic                        accept, keep, in_x, in_y;
    logic [aiwn_pkg::Q_CW-1:0]   used;
    logic [aiwn_pkg::SRC_XW-1:0] ix;
    logic [aiwn_pkg::SRC_YW-1:0] iy;
    logic [aiwn_pkg::ADDR_W-1:0] map_addr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= aiwn_pkg::RST_COEF_ONE;
            r_coef_xy  <= aiwn_pkg::RST_COEF_ZERO;
            r_offset_x <= aiwn_pkg::RST_COEF_ZERO;
            r_coef_yx  <= aiwn_pkg::RST_COEF_ZERO;
            r_coef_yy  <= aiwn_pkg::RST_COEF_ONE;
            r_offset_y <= aiwn_pkg::RST_COEF_ZERO;
            r_src_w    <= aiwn_pkg::RST_SRC_SIZE;
            r_src_h    <= aiwn_pkg::RST_SRC_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                aiwn_pkg::CFG_COEF_XX:  r_coef_xx  <= i_cfg_data;
                aiwn_pkg::CFG_COEF_XY:  r_coef_xy  <= i_cfg_data;
                aiwn_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                aiwn_pkg::CFG_COEF_YX:  r_coef_yx  <= i_cfg_data;
                aiwn_pkg::CFG_COEF_YY:  r_coef_yy  <= i_cfg_data;
                aiwn_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                aiwn_pkg::CFG_SRC_W:    r_src_w    <= i_cfg_data[aiwn_pkg::SZ_W-1:0];
                aiwn_pkg::CFG_SRC_H:    r_src_h    <= i_cfg_data[aiwn_pkg::SZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold off when queue plus in-flight stages could fill the queue
    assign used = i_q_count + aiwn_pkg::Q_CW'(r_v1) + aiwn_pkg::Q_CW'(r_v2)
                + aiwn_pkg::Q_CW'(r_v3);
    assign o_in_stall = (used >= aiwn_pkg::Q_CW'(aiwn_pkg::Q_DEPTH));
    assign accept = i_in_valid && !o_in_stall;

    // Classify: drop writes outside the store and maps outside the destination
    always_comb begin
        if (i_in_item.command == aiwn_pkg::CMD_WRITE) begin
            keep = (32'(i_in_item.coord_x) < aiwn_pkg::SRC_MAX_WIDTH)
                && (32'(i_in_item.coord_y) < aiwn_pkg::SRC_MAX_HEIGHT);
        end else begin
            keep = (32'(i_in_item.coord_x) < aiwn_pkg::DST_MAX_SIZE)
                && (32'(i_in_item.coord_y) < aiwn_pkg::DST_MAX_SIZE);
        end
        n_v1 = accept && keep;
        n_m1.cmd   = i_in_item.command;
        n_m1.x     = i_in_item.coord_x;
        n_m1.y     = i_in_item.coord_y;
        n_m1.pix   = i_in_item.pixel_in;
        n_m1.waddr = aiwn_pkg::ADDR_W'(i_in_item.coord_y)
                   * aiwn_pkg::ADDR_W'(aiwn_pkg::SRC_MAX_WIDTH)
                   + aiwn_pkg::ADDR_W'(i_in_item.coord_x);
    end

    // Products of coefficients and destination coordinates
    always_comb begin
        ext_xx = {{(aiwn_pkg::PROD_W-aiwn_pkg::COEF_W){r_coef_xx[aiwn_pkg::COEF_W-1]}}, r_coef_xx};
        ext_xy = {{(aiwn_pkg::PROD_W-aiwn_pkg::COEF_W){r_coef_xy[aiwn_pkg::COEF_W-1]}}, r_coef_xy};
        ext_yx = {{(aiwn_pkg::PROD_W-aiwn_pkg::COEF_W){r_coef_yx[aiwn_pkg::COEF_W-1]}}, r_coef_yx};
        ext_yy = {{(aiwn_pkg::PROD_W-aiwn_pkg::COEF_W){r_coef_yy[aiwn_pkg::COEF_W-1]}}, r_coef_yy};
        ext_x  = {{(aiwn_pkg::PROD_W-aiwn_pkg::CRD_W){1'b0}}, r_m1.x};
        ext_y  = {{(aiwn_pkg::PROD_W-aiwn_pkg::CRD_W){1'b0}}, r_m1.y};
        n_pxx  = ext_xx * ext_x;
        n_pxy  = ext_xy * ext_y;
        n_pyx  = ext_yx * ext_x;
        n_pyy  = ext_yy * ext_y;
    end

    // Sum products and offsets
    always_comb begin
        n_sx = {r_pxx[aiwn_pkg::PROD_W-1], r_pxx} + {r_pxy[aiwn_pkg::PROD_W-1], r_pxy}
             + {{(aiwn_pkg::ACC_W-aiwn_pkg::COEF_W){r_offset_x[aiwn_pkg::COEF_W-1]}}, r_offset_x};
        n_sy = {r_pyx[aiwn_pkg::PROD_W-1], r_pyx} + {r_pyy[aiwn_pkg::PROD_W-1], r_pyy}
             + {{(aiwn_pkg::ACC_W-aiwn_pkg::COEF_W){r_offset_y[aiwn_pkg::COEF_W-1]}}, r_offset_y};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1  <= n_m1;
        r_m2  <= r_m1;
        r_m3  <= r_m2;
        r_pxx <= n_pxx;
        r_pxy <= n_pxy;
        r_pyx <= n_pyx;
        r_pyy <= n_pyy;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
    end

    // Bounds test and source address
    always_comb begin
        in_x = aiwn_pkg::in_range(r_sx, r_src_w, aiwn_pkg::LIM_W'(aiwn_pkg::SRC_MAX_WIDTH));
        in_y = aiwn_pkg::in_range(r_sy, r_src_h, aiwn_pkg::LIM_W'(aiwn_pkg::SRC_MAX_HEIGHT));
        ix = r_sx[aiwn_pkg::FRAC_W +: aiwn_pkg::SRC_XW];
        iy = r_sy[aiwn_pkg::FRAC_W +: aiwn_pkg::SRC_YW];
        map_addr = aiwn_pkg::ADDR_W'(iy) * aiwn_pkg::ADDR_W'(aiwn_pkg::SRC_MAX_WIDTH)
                 + aiwn_pkg::ADDR_W'(ix);
        o_job.cmd    = r_m3.cmd;
        o_job.dest_x = r_m3.x;
        o_job.dest_y = r_m3.y;
        o_job.pixel  = r_m3.pix;
        o_job.addr   = (r_m3.cmd == aiwn_pkg::CMD_WRITE) ? r_m3.waddr : map_addr;
        o_job.hit    = in_x && in_y;
    end

    assign o_push = r_v3;

endmodule

>>> design/aiwn_queue.sv
// Short FIFO of classified commands between front and back end.
// Depends on aiwn_pkg; the front end guarantees it is never pushed when full.
module aiwn_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  aiwn_pkg::t_job            i_job,
    input  logic                      i_pop,
    output logic                      o_valid,
    output aiwn_pkg::t_job            o_job,
    output logic [aiwn_pkg::Q_CW-1:0] o_count
);

    aiwn_pkg::t_job            r_mem [aiwn_pkg::Q_DEPTH];
    logic [aiwn_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [aiwn_pkg::Q_CW-1:0] r_cnt;
    logic                      do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == aiwn_pkg::Q_AW'(aiwn_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == aiwn_pkg::Q_AW'(aiwn_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + aiwn_pkg::Q_CW'(i_push) - aiwn_pkg::Q_CW'(do_pop);
        end
    end

endmodule

>>> design/aiwn_back.sv
// Back end: frame store writes, sample reads and the output register.
// Depends on aiwn_pkg and aiwn_ram.
module aiwn_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  aiwn_pkg::t_job  i_q_job,
    output logic            o_q_pop,
    output logic            o_out_valid,
    output aiwn_pkg::t_res  o_out_item,
    input  logic            i_out_stall
);

    typedef struct packed {
        logic [aiwn_pkg::CRD_W-1:0] dest_x;
        logic [aiwn_pkg::CRD_W-1:0] dest_y;
        logic                       hit;
    } t_rd_meta;

    logic                        r_rd_valid;
    t_rd_meta                    r_rd_meta;
    logic                        r_out_valid;
    aiwn_pkg::t_res              r_out_item;
    logic                        move_out, is_write, ram_we, ram_re;
    logic [aiwn_pkg::PIX_W-1:0]  rdata;

    assign is_write = (i_q_job.cmd == aiwn_pkg::CMD_WRITE);
    assign move_out = r_rd_valid && (!r_out_valid || !i_out_stall);
    // Writes never wait; a map waits only for room in the read stage
    assign o_q_pop  = i_q_valid && (is_write || !r_rd_valid || move_out);
    assign ram_we   = o_q_pop && is_write;
    assign ram_re   = o_q_pop && !is_write;

    aiwn_ram #(
        .WIDTH (aiwn_pkg::PIX_W),
        .DEPTH (aiwn_pkg::FRAME_DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_job.addr),
        .i_wdata (i_q_job.pixel),
        .i_re    (ram_re),
        .i_raddr (i_q_job.addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ram_re) begin
                r_rd_valid <= 1'b1;
            end else if (move_out) begin
                r_rd_valid <= 1'b0;
            end
            if (move_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_meta.dest_x <= i_q_job.dest_x;
            r_rd_meta.dest_y <= i_q_job.dest_y;
            r_rd_meta.hit    <= i_q_job.hit;
        end
        if (move_out) begin
            r_out_item.dest_x     <= r_rd_meta.dest_x;
            r_out_item.dest_y     <= r_rd_meta.dest_y;
            r_out_item.pixel_out  <= r_rd_meta.hit ? rdata : '0;
            r_out_item.inside_res <= r_rd_meta.hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> design/aiwn_checker.sv
// Port-level checks of the affine inverse warp, bound to its top level.
// Depends on aiwn_pkg and affine_inverse_warp_nearest.
module aiwn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input aiwn_pkg::t_res             o_out_item,
    input logic                       i_out_stall
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Outside samples are black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.inside_res |-> o_out_item.pixel_out == '0)
        else $error("outside result is not black");

    // Reset drops any pending result
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties queue and pipeline, so input is open right after
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind affine_inverse_warp_nearest aiwn_checker u_aiwn_checker (.*);
